// ===== design/hlwr_pkg.sv =====
`default_nettype none

package hlwr_pkg;

  // field and datapath widths
  localparam int IN_W     = 16;              // Q8.8 input fields
  localparam int LOSS_W   = 32;              // Q16.16 result
  localparam int ACC_W    = 48;              // running sums
  localparam int CNT_W    = 17;              // nonzero weight count
  localparam int FRAC_IN  = 8;               // fraction bits of an input field
  localparam int DIV_W    = ACC_W + FRAC_IN; // dividend of the weighted mean
  localparam int DIV_STEPS = DIV_W;          // one quotient bit per cycle

  // arithmetic constants
  localparam int ONE_Q16    = 65536;         // 1.0 in Q16.16
  localparam int ONE_Q8     = 256;           // 1.0 in Q8.8
  localparam int ROUND_HALF = 128;           // half lsb before the Q8.8 drop

  // defaults for top level parameters
  localparam int MAX_ELEMENTS_DEF = 65536;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // reduction modes
  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_SUM     = 2'd1,
    MODE_MEAN    = 2'd2,
    MODE_NZ_MEAN = 2'd3
  } mode_t;

  // work handed from front to back
  typedef enum logic {
    OP_EMIT = 1'b0,
    OP_DIV  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [LOSS_W-1:0] value;  // result for OP_EMIT
    logic signed [ACC_W-1:0]  num;    // dividend for OP_DIV
    logic signed [ACC_W-1:0]  den;    // divisor for OP_DIV
    logic                     scale;  // dividend takes a Q8.8 shift
    logic                     fin;    // item closes a tensor
  } entry_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_HOLD = 2'd2
  } bk_state_t;

endpackage

`default_nettype wire

// ===== design/hlwr_queue.sv =====
`default_nettype none

module hlwr_queue #(
  parameter int DEPTH = hlwr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire hlwr_pkg::entry_t wr_entry,
  output logic                 full,
  input  wire logic            rd,
  output hlwr_pkg::entry_t     rd_entry,
  output logic                 empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  hlwr_pkg::entry_t mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full     = (count == FullCnt);
  assign empty    = (count == '0);
  assign rd_entry = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/hlwr_front.sv =====
`default_nettype none

module hlwr_front #(
  parameter int MAX_ELEMENTS = hlwr_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [1:0]                     cfg_data,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic signed [hlwr_pkg::IN_W-1:0] logit,
  input  wire logic signed [hlwr_pkg::IN_W-1:0] label,
  input  wire logic signed [hlwr_pkg::IN_W-1:0] weight,
  input  wire logic                           last_element,
  output logic                                q_push,
  output hlwr_pkg::entry_t                    q_entry,
  input  wire logic                           q_full
);

  localparam int InW   = hlwr_pkg::IN_W;
  localparam int LossW = hlwr_pkg::LOSS_W;
  localparam int AccW  = hlwr_pkg::ACC_W;
  localparam int CntW  = hlwr_pkg::CNT_W;
  localparam int FracW = hlwr_pkg::FRAC_IN;
  localparam int ZW    = InW + 2;            // 2*label - 1.0
  localparam int ZMagW = InW + 1;
  localparam int PW    = ZMagW + InW;        // |z| * |x|
  localparam int EW    = PW;                 // unweighted loss
  localparam int ProdW = EW + InW;            // loss * |w|
  localparam int RW    = ProdW - FracW;
  localparam int CntLimit = (MAX_ELEMENTS < (1 << CntW) - 1) ? MAX_ELEMENTS : (1 << CntW) - 1;
  localparam logic [CntW-1:0] CntMax = CntW'(CntLimit);
  localparam logic [EW-1:0] OneQ16 = EW'(hlwr_pkg::ONE_Q16);
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [LossW-1:0] LossMax = {1'b0, {(LossW-1){1'b1}}};
  localparam logic signed [LossW-1:0] LossMin = {1'b1, {(LossW-1){1'b0}}};
  localparam logic [RW-1:0] RPosMax = RW'(LossMax);
  localparam logic [RW-1:0] RNegMax = RW'({1'b1, {(LossW-1){1'b0}}});

  hlwr_pkg::mode_t mode;

  logic adv;
  logic accept;

  // stage a: hinge product magnitude
  logic signed [ZW-1:0] z;
  logic [ZMagW-1:0]     zmag;
  logic [InW-1:0]       xmag;
  logic [InW-1:0]       wmag_next;
  logic [PW-1:0]        a_p_next;
  logic                 a_valid;
  logic [PW-1:0]        a_p;
  logic                 a_neg;
  logic [InW-1:0]       a_wmag;
  logic signed [InW-1:0] a_w;
  logic                 a_last;

  // stage b: unweighted loss
  logic [EW-1:0]        b_e_next;
  logic                 b_valid;
  logic [EW-1:0]        b_e;
  logic [InW-1:0]       b_wmag;
  logic signed [InW-1:0] b_w;
  logic                 b_last;

  // stage c: weighted product
  logic                 c_valid;
  logic [ProdW-1:0]     c_prod;
  logic signed [InW-1:0] c_w;
  logic                 c_last;

  // stage d: rounded and saturated loss
  logic [RW-1:0]        r;
  logic signed [LossW-1:0] d_l_next;
  logic                 d_valid;
  logic signed [LossW-1:0] d_l;
  logic signed [InW-1:0] d_w;
  logic                 d_last;

  // accumulators
  logic signed [AccW-1:0] loss_total;
  logic signed [AccW-1:0] weight_total;
  logic [CntW-1:0]        nonzero_count;
  logic signed [AccW:0]   lsum;
  logic signed [AccW:0]   wsum;
  logic signed [AccW-1:0] loss_total_next;
  logic signed [AccW-1:0] weight_total_next;
  logic [CntW-1:0]        nonzero_count_next;

  // stage e: classified entry
  hlwr_pkg::entry_t e_entry_next;
  logic             e_valid_next;
  hlwr_pkg::entry_t e_entry;
  logic             e_valid;

  // pipeline moves unless a finished entry is stuck at the queue
  assign adv    = !e_valid || !q_full;
  assign full   = !adv;
  assign accept = push && adv;
  assign q_push = e_valid && !q_full;
  assign q_entry = e_entry;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= hlwr_pkg::MODE_NONE;
    end else if (cfg_write) begin
      mode <= hlwr_pkg::mode_t'(cfg_data);
    end
  end

  // stage a logic: z = 2*label - 1.0 and |z|*|x|
  always_comb begin
    z         = $signed({label[InW-1], label, 1'b0}) - ZW'(hlwr_pkg::ONE_Q8);
    zmag      = z[ZW-1] ? ZMagW'(-z) : z[ZMagW-1:0];
    xmag      = logit[InW-1] ? InW'(-logit) : logit;
    wmag_next = weight[InW-1] ? InW'(-weight) : weight;
    a_p_next  = PW'(zmag) * PW'(xmag);
  end

  // stage b logic: max(0, 1 - z*x)
  always_comb begin
    if (a_p == '0 || !a_neg) begin
      b_e_next = (a_p < OneQ16) ? OneQ16 - a_p : '0;
    end else begin
      b_e_next = OneQ16 + a_p;
    end
  end

  // stage d logic: round half away from zero, apply sign, saturate
  always_comb begin
    r = RW'((c_prod + ProdW'(hlwr_pkg::ROUND_HALF)) >> FracW);
    if (!c_w[InW-1]) begin
      d_l_next = (r > RPosMax) ? LossMax : LossW'(r);
    end else begin
      d_l_next = (r > RNegMax) ? LossMin : -LossW'(r);
    end
  end

  // saturating accumulation
  always_comb begin
    lsum = {loss_total[AccW-1], loss_total} + (AccW+1)'(d_l);
    wsum = {weight_total[AccW-1], weight_total} + (AccW+1)'(d_w);
    if (lsum[AccW] != lsum[AccW-1]) begin
      loss_total_next = lsum[AccW] ? AccMin : AccMax;
    end else begin
      loss_total_next = lsum[AccW-1:0];
    end
    if (wsum[AccW] != wsum[AccW-1]) begin
      weight_total_next = wsum[AccW] ? AccMin : AccMax;
    end else begin
      weight_total_next = wsum[AccW-1:0];
    end
    if (d_w != '0 && nonzero_count < CntMax) begin
      nonzero_count_next = nonzero_count + 1'b1;
    end else begin
      nonzero_count_next = nonzero_count;
    end
  end

  // classify: direct result or division job
  always_comb begin
    e_entry_next.op    = hlwr_pkg::OP_EMIT;
    e_entry_next.value = d_l;
    e_entry_next.num   = loss_total_next;
    e_entry_next.den   = weight_total_next;
    e_entry_next.scale = 1'b0;
    e_entry_next.fin   = d_last;
    e_valid_next       = 1'b0;
    unique case (mode)
      hlwr_pkg::MODE_NONE: begin
        e_valid_next = 1'b1;
      end
      hlwr_pkg::MODE_SUM: begin
        e_valid_next = d_last;
        if (loss_total_next > AccW'(LossMax)) begin
          e_entry_next.value = LossMax;
        end else if (loss_total_next < AccW'(LossMin)) begin
          e_entry_next.value = LossMin;
        end else begin
          e_entry_next.value = loss_total_next[LossW-1:0];
        end
      end
      hlwr_pkg::MODE_MEAN: begin
        e_valid_next = d_last;
        if (weight_total_next == '0) begin
          e_entry_next.value = '0;
        end else begin
          e_entry_next.op    = hlwr_pkg::OP_DIV;
          e_entry_next.scale = 1'b1;
        end
      end
      hlwr_pkg::MODE_NZ_MEAN: begin
        e_valid_next     = d_last;
        e_entry_next.den = $signed(AccW'(nonzero_count_next));
        if (nonzero_count_next == '0) begin
          e_entry_next.value = '0;
        end else begin
          e_entry_next.op = hlwr_pkg::OP_DIV;
        end
      end
      default: begin
        e_valid_next = 1'b0;
      end
    endcase
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid && e_valid_next;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_p     <= a_p_next;
      a_neg   <= z[ZW-1] ^ logit[InW-1];
      a_wmag  <= wmag_next;
      a_w     <= weight;
      a_last  <= last_element;
      b_e     <= b_e_next;
      b_wmag  <= a_wmag;
      b_w     <= a_w;
      b_last  <= a_last;
      c_prod  <= ProdW'(b_e) * ProdW'(b_wmag);
      c_w     <= b_w;
      c_last  <= b_last;
      d_l     <= d_l_next;
      d_w     <= c_w;
      d_last  <= c_last;
      e_entry <= e_entry_next;
    end
  end

  // running sums, cleared after the closing item
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_total    <= '0;
      weight_total  <= '0;
      nonzero_count <= '0;
    end else if (adv && d_valid) begin
      if (d_last) begin
        loss_total    <= '0;
        weight_total  <= '0;
        nonzero_count <= '0;
      end else begin
        loss_total    <= loss_total_next;
        weight_total  <= weight_total_next;
        nonzero_count <= nonzero_count_next;
      end
    end
  end

  // sums restart after a closing item
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (adv && d_valid && d_last) |=>
      (loss_total == '0 && weight_total == '0 && nonzero_count == '0))
    else $error("accumulators not cleared after closing item");

  // unreduced mode yields an entry for every item
  a_none_emits: assert property (@(posedge clk) disable iff (rst)
    (adv && d_valid && mode == hlwr_pkg::MODE_NONE) |=> e_valid)
    else $error("item lost in unreduced mode");

  // a stalled entry stays put
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (e_valid && q_full) |=> e_valid)
    else $error("entry dropped while queue full");

endmodule

`default_nettype wire

// ===== design/hlwr_back.sv =====
`default_nettype none

module hlwr_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire hlwr_pkg::entry_t                 q_entry,
  input  wire logic                             q_empty,
  output logic                                  q_pop,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic signed [hlwr_pkg::LOSS_W-1:0]    loss_value,
  output logic                                  is_final
);

  localparam int AccW  = hlwr_pkg::ACC_W;
  localparam int DivW  = hlwr_pkg::DIV_W;
  localparam int LossW = hlwr_pkg::LOSS_W;
  localparam int FracW = hlwr_pkg::FRAC_IN;
  localparam int StepW = $clog2(hlwr_pkg::DIV_STEPS);
  localparam logic [StepW-1:0] LastStep = StepW'(hlwr_pkg::DIV_STEPS - 1);
  localparam logic [DivW-1:0] QPosMax = DivW'({1'b0, {(LossW-1){1'b1}}});
  localparam logic [DivW-1:0] QNegMax = DivW'({1'b1, {(LossW-1){1'b0}}});
  localparam logic signed [LossW-1:0] LossMax = {1'b0, {(LossW-1){1'b1}}};
  localparam logic signed [LossW-1:0] LossMin = {1'b1, {(LossW-1){1'b0}}};

  hlwr_pkg::bk_state_t state;
  hlwr_pkg::bk_state_t state_next;

  logic out_valid;
  logic out_free;
  logic div_load;
  logic emit_load;
  logic res_load;

  // divider registers
  logic [AccW-1:0]  rem;
  logic [DivW-1:0]  quo;
  logic [AccW-1:0]  dmag;
  logic             neg;
  logic             fin;
  logic [StepW-1:0] step;

  // divider datapath
  logic [AccW-1:0]  nmag_next;
  logic [AccW-1:0]  dmag_next;
  logic [DivW-1:0]  dividend_next;
  logic [AccW:0]    shifted;
  logic             fits;
  logic [AccW:0]    diff;
  logic [AccW-1:0]  rem_next;
  logic signed [LossW-1:0] div_result;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hlwr_pkg::BK_IDLE: begin
        if (!q_empty && q_entry.op == hlwr_pkg::OP_DIV) begin
          state_next = hlwr_pkg::BK_DIV;
        end
      end
      hlwr_pkg::BK_DIV: begin
        if (step == LastStep) begin
          state_next = hlwr_pkg::BK_HOLD;
        end
      end
      hlwr_pkg::BK_HOLD: begin
        if (out_free) begin
          state_next = hlwr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = hlwr_pkg::BK_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop     = 1'b0;
    div_load  = 1'b0;
    emit_load = 1'b0;
    res_load  = 1'b0;
    unique case (state)
      hlwr_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (q_entry.op == hlwr_pkg::OP_DIV) begin
            q_pop    = 1'b1;
            div_load = 1'b1;
          end else if (out_free) begin
            q_pop     = 1'b1;
            emit_load = 1'b1;
          end
        end
      end
      hlwr_pkg::BK_DIV: begin
        q_pop = 1'b0;
      end
      hlwr_pkg::BK_HOLD: begin
        res_load = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // operand magnitudes at load
  always_comb begin
    nmag_next = q_entry.num[AccW-1] ? AccW'(-q_entry.num) : q_entry.num;
    dmag_next = q_entry.den[AccW-1] ? AccW'(-q_entry.den) : q_entry.den;
    if (q_entry.scale) begin
      dividend_next = {nmag_next, {FracW{1'b0}}};
    end else begin
      dividend_next = {{FracW{1'b0}}, nmag_next};
    end
  end

  // one restoring step per cycle
  always_comb begin
    shifted  = {rem, quo[DivW-1]};
    fits     = (shifted >= {1'b0, dmag});
    diff     = shifted - {1'b0, dmag};
    rem_next = fits ? diff[AccW-1:0] : shifted[AccW-1:0];
  end

  // sign and saturate the quotient
  always_comb begin
    if (!neg) begin
      div_result = (quo > QPosMax) ? LossMax : LossW'(quo);
    end else begin
      div_result = (quo > QNegMax) ? LossMin : -LossW'(quo);
    end
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hlwr_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_load || res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // divider iteration
  always_ff @(posedge clk) begin
    if (div_load) begin
      rem  <= '0;
      quo  <= dividend_next;
      dmag <= dmag_next;
      neg  <= q_entry.num[AccW-1] ^ q_entry.den[AccW-1];
      fin  <= q_entry.fin;
      step <= '0;
    end else if (state == hlwr_pkg::BK_DIV) begin
      rem  <= rem_next;
      quo  <= {quo[DivW-2:0], fits};
      step <= step + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      loss_value <= q_entry.value;
      is_final   <= q_entry.fin;
    end else if (res_load) begin
      loss_value <= div_result;
      is_final   <= fin;
    end
  end

  // the division ends on its last step
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == hlwr_pkg::BK_DIV && step == LastStep) |=> state == hlwr_pkg::BK_HOLD)
    else $error("division did not finish on its last step");

  // queue is read only when idle and holding an item
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == hlwr_pkg::BK_IDLE && !q_empty))
    else $error("queue read outside idle or while empty");

  // a finished quotient reaches the result register
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (state == hlwr_pkg::BK_HOLD && out_free) |=> (out_valid && state == hlwr_pkg::BK_IDLE))
    else $error("quotient not delivered");

endmodule

`default_nettype wire

// ===== design/hinge_loss_weighted_reduce.sv =====
// Weighted hinge loss with optional sum / mean reduction.
// Throughput: one item per cycle into a five-stage front pipeline (two multipliers),
// held while full is high. An unreduced result passes the front stages and the queue;
// a mean also runs through the shared bit-serial divider, one quotient bit per cycle.
// Reset (rst, synchronous): mode 0, sums and counts zero, queue and result empty.
`default_nettype none

module hinge_loss_weighted_reduce #(
  parameter int MAX_ELEMENTS = hlwr_pkg::MAX_ELEMENTS_DEF,
  parameter int QUEUE_DEPTH  = hlwr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [1:0]                         cfg_data,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic signed [hlwr_pkg::IN_W-1:0]   logit,
  input  wire logic signed [hlwr_pkg::IN_W-1:0]   label,
  input  wire logic signed [hlwr_pkg::IN_W-1:0]   weight,
  input  wire logic                               last_element,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic signed [hlwr_pkg::LOSS_W-1:0]      loss_value,
  output logic                                    is_final
);

  logic             q_wr;
  logic             q_full;
  logic             q_rd;
  logic             q_empty;
  hlwr_pkg::entry_t q_wr_entry;
  hlwr_pkg::entry_t q_rd_entry;

  // loss pipeline, accumulation and classification
  hlwr_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .logit        (logit),
    .label        (label),
    .weight       (weight),
    .last_element (last_element),
    .q_push       (q_wr),
    .q_entry      (q_wr_entry),
    .q_full       (q_full)
  );

  // decoupling queue
  hlwr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .rd       (q_rd),
    .rd_entry (q_rd_entry),
    .empty    (q_empty)
  );

  // divider and result register
  hlwr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_entry    (q_rd_entry),
    .q_empty    (q_empty),
    .q_pop      (q_rd),
    .empty      (empty),
    .pop        (pop),
    .loss_value (loss_value),
    .is_final   (is_final)
  );

endmodule

`default_nettype wire

// ===== tb/sv/hinge_loss_weighted_reduce_check.sv =====
module hinge_loss_weighted_reduce_check (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [1:0]                       cfg_data,
  input  wire logic                             push,
  input  wire logic                             full,
  input  wire logic signed [hlwr_pkg::IN_W-1:0] logit,
  input  wire logic signed [hlwr_pkg::IN_W-1:0] label,
  input  wire logic signed [hlwr_pkg::IN_W-1:0] weight,
  input  wire logic                             last_element,
  input  wire logic                             empty,
  input  wire logic                             pop,
  input  wire logic signed [hlwr_pkg::LOSS_W-1:0] loss_value,
  input  wire logic                             is_final,
  output int                                    mismatches,
  output int                                    pending,
  output int                                    items_in,
  output int                                    results_out
);
  timeunit 1ns;
  timeprecision 1ps;
  import hlwr_pkg::*;

  localparam longint LOSS_MAX = 64'sd2147483647;
  localparam longint LOSS_MIN = -64'sd2147483648;
  localparam longint SUM_MAX  = 64'sd140737488355327;
  localparam longint SUM_MIN  = -SUM_MAX - 1;
  localparam longint E_LIMIT  = 64'sd1099511627776;
  localparam int     NZ_MAX   = (MAX_ELEMENTS_DEF < 131071) ? MAX_ELEMENTS_DEF : 131071;

  typedef struct {
    logic signed [LOSS_W-1:0] value;
    logic                     fin;
  } loss_rec_t;

  // predicted results, oldest first
  loss_rec_t expected_losses[$];

  // mirrored block state
  mode_t  mode = MODE_NONE;
  longint loss_sum = 0;
  longint weight_sum = 0;
  int     nz_count = 0;
  int     fails = 0;
  int     n_in = 0;
  int     n_out = 0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // fold one element into the sums, return 1 when it yields a result
  function automatic bit fold_element(input longint x, input longint y, input longint w,
                                      input bit fin, output loss_rec_t rec);
    longint z, zm, xm, p, e, r, l, red;
    bit     opposed;
    // hinge margin: sign of (2*label - 1) against the logit
    z       = 2 * y - ONE_Q8;
    zm      = (z < 0) ? -z : z;
    xm      = (x < 0) ? -x : x;
    p       = zm * xm;
    opposed = (z < 0) != (x < 0);
    if (p == 0 || !opposed) e = (p < ONE_Q16) ? ONE_Q16 - p : 0;
    else e = ONE_Q16 + p;
    if (e > E_LIMIT) e = E_LIMIT;
    // weight it, round half away from zero, saturate
    r = (e * ((w < 0) ? -w : w) + ROUND_HALF) >> FRAC_IN;
    if (r > E_LIMIT) r = E_LIMIT;
    l = clamp((w < 0) ? -r : r, LOSS_MIN, LOSS_MAX);
    // running sums advance in every mode
    loss_sum   = clamp(loss_sum + l, SUM_MIN, SUM_MAX);
    weight_sum = clamp(weight_sum + w, SUM_MIN, SUM_MAX);
    if (w != 0 && nz_count < NZ_MAX) nz_count++;
    red = 0;
    case (mode)
      MODE_SUM:     red = clamp(loss_sum, LOSS_MIN, LOSS_MAX);
      MODE_MEAN:    red = (weight_sum == 0) ? 0 :
                          clamp((loss_sum * ONE_Q8) / weight_sum, LOSS_MIN, LOSS_MAX);
      MODE_NZ_MEAN: red = (nz_count == 0) ? 0 :
                          clamp(loss_sum / longint'(nz_count), LOSS_MIN, LOSS_MAX);
      default:      red = 0;
    endcase
    rec.value = (mode == MODE_NONE) ? l[LOSS_W-1:0] : red[LOSS_W-1:0];
    rec.fin   = fin;
    if (fin) begin
      loss_sum   = 0;
      weight_sum = 0;
      nz_count   = 0;
    end
    return (mode == MODE_NONE) || fin;
  endfunction

  // watch config, result and input channels
  always @(posedge clk) begin : watch
    loss_rec_t want;
    loss_rec_t rec;
    if (rst) begin
      mode       = MODE_NONE;
      loss_sum   = 0;
      weight_sum = 0;
      nz_count   = 0;
      expected_losses.delete();
    end else begin
      if (cfg_write) mode = mode_t'(cfg_data);
      if (pop && !empty) begin
        n_out++;
        if (expected_losses.size() == 0) begin
          fails++;
          $display("%0t unexpected result: expected none, got loss_value %0d is_final %0b",
                   $time, loss_value, is_final);
        end else begin
          want = expected_losses.pop_front();
          if (loss_value !== want.value) begin
            fails++;
            $display("%0t loss_value mismatch: expected %0d, got %0d",
                     $time, want.value, loss_value);
          end
          if (is_final !== want.fin) begin
            fails++;
            $display("%0t is_final mismatch: expected %0b, got %0b",
                     $time, want.fin, is_final);
          end
        end
      end
      if (push && !full) begin
        n_in++;
        if (fold_element(logit, label, weight, last_element, rec))
          expected_losses.push_back(rec);
      end
    end
    mismatches  <= fails;
    pending     <= expected_losses.size();
    items_in    <= n_in;
    results_out <= n_out;
  end

endmodule

// ===== tb/sv/hinge_loss_weighted_reduce_tb.sv =====
module hinge_loss_weighted_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hlwr_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 80;
  localparam int SEG_ITEMS     = 50;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [1:0]               cfg_data = '0;
  logic                     push = 1'b0;
  logic                     full;
  logic signed [IN_W-1:0]   logit = '0;
  logic signed [IN_W-1:0]   label = '0;
  logic signed [IN_W-1:0]   weight = '0;
  logic                     last_element = 1'b0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic signed [LOSS_W-1:0] loss_value;
  logic                     is_final;

  int send_idle = 0;
  int pop_stall = 0;
  int quiet = 0;
  int mismatches;
  int pending;
  int items_in;
  int results_out;

  hinge_loss_weighted_reduce uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .logit        (logit),
    .label        (label),
    .weight       (weight),
    .last_element (last_element),
    .empty        (empty),
    .pop          (pop),
    .loss_value   (loss_value),
    .is_final     (is_final)
  );

  hinge_loss_weighted_reduce_check loss_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .logit        (logit),
    .label        (label),
    .weight       (weight),
    .last_element (last_element),
    .empty        (empty),
    .pop          (pop),
    .loss_value   (loss_value),
    .is_final     (is_final),
    .mismatches   (mismatches),
    .pending      (pending),
    .items_in     (items_in),
    .results_out  (results_out)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side, random stalls
  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99) >= pop_stall);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t watchdog: no item moved for %0d cycles", $time, quiet);
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // present one item, hold until accepted
  task automatic send_item(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
                           input logic signed [IN_W-1:0] w, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    logit        <= x;
    label        <= y;
    weight       <= w;
    last_element <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // stop sending until every predicted result has come out
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mode change only while the block is quiet
  task automatic set_mode(input mode_t m);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // one tensor of random elements, last flag on the final one
  task automatic send_tensor(input int len);
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] w;
    logic signed [IN_W-1:0] w_scalar;
    bit                     scalar;
    scalar   = ($urandom_range(3) == 0);
    w_scalar = IN_W'($urandom_range(1023) - 512);
    for (int i = 0; i < len; i++) begin
      // labels mostly 0.0 / 1.0, logits half the time near the margin
      y = ($urandom_range(9) < 7) ? ($urandom_range(1) ? IN_W'(ONE_Q8) : IN_W'(0)) :
                                     IN_W'($urandom());
      x = $urandom_range(1) ? IN_W'($urandom_range(1023) - 512) : IN_W'($urandom());
      case ($urandom_range(19))
        0, 1, 2:       w = '0;
        3, 4, 5, 6, 7,
        8, 9, 10, 11,
        12, 13:        w = IN_W'($urandom_range(767) - 256);
        default:       w = IN_W'($urandom());
      endcase
      if (scalar) w = w_scalar;
      send_item(x, y, w, i == len - 1);
    end
  endtask

  initial begin
    mode_t seg_modes [8];
    int    sent;
    int    len;
    bit    paused;
    seg_modes = '{MODE_NONE, MODE_SUM, MODE_MEAN, MODE_NZ_MEAN,
                  MODE_NZ_MEAN, MODE_MEAN, MODE_SUM, MODE_NONE};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unreduced extremes: wide margin, large losses of both signs, saturation, label extremes
    send_item(32767, 256, 32767, 1'b0);
    send_item(-32768, 256, 32767, 1'b0);
    send_item(-32768, 256, -32768, 1'b0);
    send_item(32767, -32768, 256, 1'b0);
    send_item(0, 0, 256, 1'b0);
    send_item(77, 128, -300, 1'b0);
    send_item(256, 256, 0, 1'b1);

    // sums run while unreduced, emitted under the sum mode
    send_item(100, 0, 300, 1'b0);
    set_mode(MODE_SUM);
    send_item(-50, 256, 512, 1'b1);
    // saturating sum
    send_item(-32768, 256, 32767, 1'b0);
    send_item(-32768, 256, 32767, 1'b1);

    // weighted mean: weights cancel, then quotient saturates
    set_mode(MODE_MEAN);
    send_item(-100, 256, 256, 1'b0);
    send_item(40, 0, -256, 1'b1);
    send_item(-32768, 256, 32767, 1'b0);
    send_item(32767, 256, -32766, 1'b1);

    // nonzero-count mean: no nonzero weight, then a normal tensor
    set_mode(MODE_NZ_MEAN);
    send_item(-300, 256, 0, 1'b0);
    send_item(300, 0, 0, 1'b1);
    send_item(500, 0, 256, 1'b0);
    send_item(0, 256, 0, 1'b0);
    send_item(-700, 256, -512, 1'b1);

    // random tensors per mode, cycling the idle profiles
    for (int seg = 0; seg < 8; seg++) begin
      set_mode(seg_modes[seg]);
      case (seg % 4)
        0: begin
          send_idle = 0;
          pop_stall = 0;
        end
        1: begin
          send_idle = 73;
          pop_stall = 0;
        end
        2: begin
          send_idle = 0;
          pop_stall = 73;
        end
        default: begin
          send_idle = 14;
          pop_stall = 14;
        end
      endcase
      sent   = 0;
      paused = 1'b0;
      while (sent < SEG_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 1);
        send_tensor(len);
        sent += len;
        // let the output side run dry mid-segment
        if (seg % 2 == 1 && !paused && sent >= SEG_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    // drain and settle
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items in, %0d results out, all four reduction modes", items_in,
             results_out);
    $display("with field extremes, zero denominators and idle/stall on both sides");
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      if (pending != 0) $display("%0t %0d expected results never came out", $time, pending);
      $display("FAIL");
    end
    $finish;
  end

endmodule
